// File: hw/rtl/permission_table_engine_top_assert.svh
// Assertion macros for the permission table engine.
`ifndef PERMISSION_TABLE_ENGINE_TOP_ASSERT_SVH
`define PERMISSION_TABLE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pte assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pte assertion failed");

`endif

// File: hw/rtl/pte_pkg.sv
// Shared types and constants of the permission table engine.
package pte_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int KEY_BITS      = 16;
  localparam int PERM_BITS     = 8;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_SET = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CLEAR = 2'd1,
    ST_BAD_SET   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    req_kind_t             req_type;
    logic [KEY_BITS-1:0]   target_key;
    logic [KEY_BITS-1:0]   caller_key;
    logic                  caller_is_root;
    logic [PERM_BITS-1:0]  clear_bits;
    logic [PERM_BITS-1:0]  set_bits;
  } request_t;

  typedef struct packed {
    logic [PERM_BITS-1:0] permissions;
    status_t              status;
  } result_t;

endpackage

// File: hw/rtl/pte_in_reg.sv
// Input register of the permission table engine.
module pte_in_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [pte_pkg::KEY_BITS-1:0] in_target_key,
  input  logic [pte_pkg::KEY_BITS-1:0] in_caller_key,
  input  logic                         in_caller_is_root,
  input  logic [pte_pkg::PERM_BITS-1:0] in_clear_bits,
  input  logic [pte_pkg::PERM_BITS-1:0] in_set_bits,
  input  logic                         adv,
  output logic                         req_vld_r,
  output pte_pkg::request_t            req_r
);
  import pte_pkg::*;

  logic req_vld_nxt;
  logic take;

  assign in_stall    = req_vld_r & ~adv;
  assign take        = in_valid & ~in_stall;
  assign req_vld_nxt = take | (req_vld_r & ~adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r.req_type       <= req_kind_t'(in_req_type);
      req_r.target_key     <= in_target_key;
      req_r.caller_key     <= in_caller_key;
      req_r.caller_is_root <= in_caller_is_root;
      req_r.clear_bits     <= in_clear_bits;
      req_r.set_bits       <= in_set_bits;
    end
  end

endmodule

// File: hw/rtl/pte_table.sv
// Permission table: parallel key match, free-slot pick, update and result.
module pte_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  pte_pkg::request_t             req,
  input  logic [pte_pkg::PERM_BITS-1:0] valid_mask,
  output pte_pkg::result_t              res
);
  import pte_pkg::*;

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [KEY_BITS-1:0]      key_r   [TABLE_ENTRIES];
  logic [PERM_BITS-1:0]     flags_r [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] t_hit, c_hit, t_oh, c_oh, free_oh;
  logic [PERM_BITS-1:0]     t_flags, c_flags, caller_perm, target_perm;
  logic [PERM_BITS-1:0]     eff_set, new_flags;
  logic                     bad_clr, bad_set, t_any, free_any, target_zero;
  logic                     do_set, upd_en, ins_en;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      t_hit[i] = valid_r[i] & (key_r[i] == req.target_key);
      c_hit[i] = valid_r[i] & (key_r[i] == req.caller_key);
    end
  end

  // lowest set bit wins
  assign t_oh    = t_hit & (~t_hit + TABLE_ENTRIES'(1));
  assign c_oh    = c_hit & (~c_hit + TABLE_ENTRIES'(1));
  assign free_oh = ~valid_r & (valid_r + TABLE_ENTRIES'(1));

  always_comb begin
    t_flags = '0;
    c_flags = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      t_flags = t_flags | (flags_r[i] & {PERM_BITS{t_oh[i]}});
      c_flags = c_flags | (flags_r[i] & {PERM_BITS{c_oh[i]}});
    end
  end

  assign t_any       = |t_oh;
  assign free_any    = |free_oh;
  assign target_zero = (req.target_key == '0);
  assign target_perm = target_zero ? valid_mask : t_flags;
  assign caller_perm = (req.caller_key == '0) ? valid_mask : c_flags;
  assign bad_clr     = |(req.clear_bits & ~valid_mask);
  assign bad_set     = |(req.set_bits & ~valid_mask);
  assign eff_set     = req.caller_is_root ? req.set_bits : (req.set_bits & caller_perm);
  assign new_flags   = (t_flags & ~req.clear_bits) | eff_set;

  assign do_set = adv & (req.req_type == REQ_SET) & ~bad_clr & ~bad_set & ~target_zero;
  assign upd_en = do_set & t_any;
  assign ins_en = do_set & ~t_any & (|eff_set) & free_any;

  always_comb begin
    res.permissions = '0;
    res.status      = ST_OK;
    priority if (req.req_type == REQ_GET) begin
      res.permissions = target_perm;
    end else if (bad_clr) begin
      res.status = ST_BAD_CLEAR;
    end else if (bad_set) begin
      res.status = ST_BAD_SET;
    end else if (!target_zero && !t_any && (|eff_set) && !free_any) begin
      res.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (upd_en && t_oh[i]) begin
          valid_r[i] <= |new_flags;
        end else if (ins_en && free_oh[i]) begin
          valid_r[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (upd_en && t_oh[i]) begin
        flags_r[i] <= new_flags;
      end else if (ins_en && free_oh[i]) begin
        flags_r[i] <= eff_set;
        key_r[i]   <= req.target_key;
      end
    end
  end

endmodule

// File: hw/rtl/pte_out_reg.sv
// Result register of the permission table engine.
module pte_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  pte_pkg::result_t              res,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pte_pkg::PERM_BITS-1:0] out_permissions,
  output logic [1:0]                    out_status
);
  import pte_pkg::*;

  logic    out_vld_r, out_vld_nxt;
  result_t res_r;

  assign out_vld_nxt = adv | (out_vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_permissions = res_r.permissions;
  assign out_status      = 2'(res_r.status);

endmodule

// File: hw/rtl/permission_table_engine_top.sv
// Top level of the permission table engine.
//
// Usage:
//   in_*   request channel (valid/stall): get or set of one key's permissions.
//   out_*  result channel (valid/stall): permissions read and a status code.
//   cfg_*  write channel (valid/ready) for valid_mask; write only while idle.
// A request accepted into the input register goes through the table match,
// free-slot pick and update, and its result is then registered in the result
// register that drives out_valid; out_stall can hold it in the input register.
// While out_stall is low, one request per cycle is sustained; the table update
// lands at the same edge that registers the result, so back-to-back requests
// see each other's writes. The single-cycle rate is set by the 16-way parallel
// key compare against the flip-flop table.
// When out_stall holds a finished result, the input register keeps its request
// and in_stall rises; no request is lost or repeated.
// Reset clears all entries to absent and sets valid_mask to all ones; key and
// flag storage is not cleared and is ignored until written.
module permission_table_engine_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [pte_pkg::KEY_BITS-1:0]  in_target_key,
  input  logic [pte_pkg::KEY_BITS-1:0]  in_caller_key,
  input  logic                          in_caller_is_root,
  input  logic [pte_pkg::PERM_BITS-1:0] in_clear_bits,
  input  logic [pte_pkg::PERM_BITS-1:0] in_set_bits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pte_pkg::PERM_BITS-1:0] out_permissions,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pte_pkg::PERM_BITS-1:0] cfg_valid_mask
);
  import pte_pkg::*;

  logic                 req_vld_r;
  request_t             req_r;
  result_t              res;
  logic                 adv;
  logic [PERM_BITS-1:0] valid_mask_r;

  assign cfg_ready = 1'b1;
  assign adv       = req_vld_r & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_mask_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      valid_mask_r <= cfg_valid_mask;
    end
  end

  pte_in_reg u_in_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_target_key     (in_target_key),
    .in_caller_key     (in_caller_key),
    .in_caller_is_root (in_caller_is_root),
    .in_clear_bits     (in_clear_bits),
    .in_set_bits       (in_set_bits),
    .adv               (adv),
    .req_vld_r         (req_vld_r),
    .req_r             (req_r)
  );

  pte_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .req        (req_r),
    .valid_mask (valid_mask_r),
    .res        (res)
  );

  pte_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .res             (res),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_permissions (out_permissions),
    .out_status      (out_status)
  );

`include "permission_table_engine_top_assert.svh"

  `PTE_ASSERT_IMP(a_stall_needs_req, in_stall, req_vld_r)
  `PTE_ASSERT_NXT(a_adv_gives_result, adv, out_valid)
  `PTE_ASSERT_NXT(a_set_zero_perm, adv && (req_r.req_type == REQ_SET), out_permissions == '0)
  `PTE_ASSERT_NXT(a_get_status_ok, adv && (req_r.req_type == REQ_GET), out_status == 2'(ST_OK))

endmodule

// File: dv/tb_top.sv
// Self-checking testbench of the permission table engine: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;
  import pte_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic                 new_mask_en;
    logic [PERM_BITS-1:0] new_mask;
    request_t             req;
    logic                 known;
    result_t              want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [14] = '{
    '{1'b0, 8'h00, '{REQ_GET, 16'h0000, 16'h0000, 1'b0, 8'h00, 8'h00}, 1'b1, '{8'hFF, ST_OK}},
    '{1'b0, 8'h00, '{REQ_GET, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 8'hFF}, 1'b1, '{8'h00, ST_OK}},
    '{1'b0, 8'h00, '{REQ_SET, 16'h0005, 16'h0000, 1'b1, 8'h00, 8'hFF}, 1'b1, '{8'h00, ST_OK}},
    '{1'b0, 8'h00, '{REQ_SET, 16'h0000, 16'h0005, 1'b1, 8'h00, 8'h0F}, 1'b1, '{8'h00, ST_OK}},
    '{1'b0, 8'h00, '{REQ_SET, 16'hFFFF, 16'h0005, 1'b0, 8'h00, 8'hF0}, 1'b0, '{8'h00, ST_OK}},
    '{1'b0, 8'h00, '{REQ_SET, 16'h0007, 16'hABCD, 1'b0, 8'h00, 8'hFF}, 1'b0, '{8'h00, ST_OK}},
    '{1'b0, 8'h00, '{REQ_SET, 16'h0005, 16'h0000, 1'b1, 8'hFF, 8'h00}, 1'b0, '{8'h00, ST_OK}},
    '{1'b0, 8'h00, '{REQ_GET, 16'h0005, 16'h0000, 1'b0, 8'h00, 8'h00}, 1'b0, '{8'h00, ST_OK}},
    '{1'b1, 8'h0F, '{REQ_SET, 16'h0001, 16'h0000, 1'b1, 8'hF0, 8'h00}, 1'b1,
      '{8'h00, ST_BAD_CLEAR}},
    '{1'b0, 8'h00, '{REQ_SET, 16'h0001, 16'h0000, 1'b1, 8'h00, 8'h10}, 1'b1,
      '{8'h00, ST_BAD_SET}},
    '{1'b0, 8'h00, '{REQ_SET, 16'h0001, 16'h0000, 1'b1, 8'h80, 8'h80}, 1'b1,
      '{8'h00, ST_BAD_CLEAR}},
    '{1'b0, 8'h00, '{REQ_GET, 16'h0000, 16'h0000, 1'b0, 8'h00, 8'h00}, 1'b1, '{8'h0F, ST_OK}},
    '{1'b0, 8'h00, '{REQ_GET, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00}, 1'b0, '{8'h00, ST_OK}},
    '{1'b1, 8'hFF, '{REQ_GET, 16'h0007, 16'h0000, 1'b0, 8'h00, 8'h00}, 1'b0, '{8'h00, ST_OK}}
  };

  localparam logic [PERM_BITS-1:0] PHASE_MASKS [8] = '{
    8'hFF, 8'h0F, 8'h00, 8'h5A, 8'h80, 8'h01, 8'hC3, 8'hFF
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_req_type;
  logic [KEY_BITS-1:0]  in_target_key;
  logic [KEY_BITS-1:0]  in_caller_key;
  logic                 in_caller_is_root;
  logic [PERM_BITS-1:0] in_clear_bits;
  logic [PERM_BITS-1:0] in_set_bits;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PERM_BITS-1:0] out_permissions;
  logic [1:0]           out_status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [PERM_BITS-1:0] cfg_valid_mask;

  // shadow of the permission table
  logic [PERM_BITS-1:0] shadow_mask;
  logic                 shadow_used  [TABLE_ENTRIES];
  logic [KEY_BITS-1:0]  shadow_key   [TABLE_ENTRIES];
  logic [PERM_BITS-1:0] shadow_flags [TABLE_ENTRIES];

  result_t pending_perm_results [$];
  result_t head_result;
  int      mismatches = 0;
  int      stall_left = 0;
  bit      rx_quiet = 1'b0;
  bit      tx_quiet = 1'b0;
  int      cycle_count;

  permission_table_engine_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_target_key     (in_target_key),
    .in_caller_key     (in_caller_key),
    .in_caller_is_root (in_caller_is_root),
    .in_clear_bits     (in_clear_bits),
    .in_set_bits       (in_set_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_permissions   (out_permissions),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_valid_mask    (cfg_valid_mask)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int slot_of(input logic [KEY_BITS-1:0] key);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (shadow_used[i] && shadow_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic logic [PERM_BITS-1:0] perms_of(input logic [KEY_BITS-1:0] key);
    int s;
    if (key == '0) return shadow_mask;
    s = slot_of(key);
    return (s < 0) ? '0 : shadow_flags[s];
  endfunction

  function automatic result_t process_permission_request(input request_t r);
    result_t              res;
    logic [PERM_BITS-1:0] grant;
    int                   s;
    int                   free_slot;
    res.permissions = '0;
    res.status      = ST_OK;
    grant           = r.set_bits;
    if (r.req_type == REQ_GET) begin
      res.permissions = perms_of(r.target_key);
    end else if ((r.clear_bits & ~shadow_mask) != '0) begin
      res.status = ST_BAD_CLEAR;
    end else if ((grant & ~shadow_mask) != '0) begin
      res.status = ST_BAD_SET;
    end else begin
      if (!r.caller_is_root) grant &= perms_of(r.caller_key);
      if (r.target_key != '0) begin
        s = slot_of(r.target_key);
        if (s >= 0) begin
          shadow_flags[s] = (shadow_flags[s] & ~r.clear_bits) | grant;
          if (shadow_flags[s] == '0) shadow_used[s] = 1'b0;
        end else if (grant != '0) begin
          free_slot = -1;
          for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!shadow_used[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            res.status = ST_FULL;
          end else begin
            shadow_used[free_slot]  = 1'b1;
            shadow_key[free_slot]   = r.target_key;
            shadow_flags[free_slot] = grant;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic logic [KEY_BITS-1:0] pool_key(input int idx);
    return 16'(16'h2B4D * (idx + 1));
  endfunction

  function automatic logic [KEY_BITS-1:0] random_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return 16'($urandom_range(0, 65535));
    if (pick == 2) return 16'hFFFF;
    return pool_key($urandom_range(0, 23));
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    r.req_type       = ($urandom_range(0, 2) == 0) ? REQ_GET : REQ_SET;
    r.target_key     = random_key();
    r.caller_key     = random_key();
    r.caller_is_root = 1'($urandom_range(0, 1));
    r.clear_bits     = 8'($urandom);
    r.set_bits       = 8'($urandom);
    pick = $urandom_range(0, 9);
    // revoke-all requests keep entries leaving the table
    if (pick < 3) begin
      r.clear_bits = shadow_mask;
      r.set_bits   = '0;
    end else if (pick < 8) begin
      r.clear_bits &= shadow_mask;
      r.set_bits   &= shadow_mask;
    end
    return r;
  endfunction

  task automatic send_request(input request_t r, input logic known, input result_t want);
    result_t model_res;
    in_valid          <= 1'b1;
    in_req_type       <= r.req_type;
    in_target_key     <= r.target_key;
    in_caller_key     <= r.caller_key;
    in_caller_is_root <= r.caller_is_root;
    in_clear_bits     <= r.clear_bits;
    in_set_bits       <= r.set_bits;
    do @(posedge clk); while (in_stall);
    model_res = process_permission_request(r);
    pending_perm_results.push_back(known ? want : model_res);
    if (!tx_quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_perm_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_valid_mask(input logic [PERM_BITS-1:0] mask);
    cfg_valid      <= 1'b1;
    cfg_valid_mask <= mask;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    shadow_mask = mask;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_perm_results.size() == 0) begin
        $error("unexpected result: permissions %0h status %0d", out_permissions, out_status);
        mismatches++;
      end else begin
        head_result = pending_perm_results.pop_front();
        if (out_permissions !== head_result.permissions) begin
          $error("permissions: expected %0h, actual %0h", head_result.permissions,
                 out_permissions);
          mismatches++;
        end
        if (out_status !== head_result.status) begin
          $error("status: expected %0d, actual %0d", head_result.status, out_status);
          mismatches++;
        end
      end
    end
    if (!rst_n || rx_quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [PERM_BITS-1:0] phase_mask;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_req_type       <= 1'b0;
    in_target_key     <= '0;
    in_caller_key     <= '0;
    in_caller_is_root <= 1'b0;
    in_clear_bits     <= '0;
    in_set_bits       <= '0;
    cfg_valid         <= 1'b0;
    cfg_valid_mask    <= '0;
    shadow_mask = '1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_used[i]  = 1'b0;
      shadow_key[i]   = '0;
      shadow_flags[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].new_mask_en) begin
        wait_idle();
        write_valid_mask(DIRECTED_ROWS[i].new_mask);
      end
      send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
    end

    // fill the table, then one more insert must come back full
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_request('{REQ_SET, pool_key(i), 16'h0000, 1'b1, 8'h00, 8'h01}, 1'b0, '0);
    send_request('{REQ_SET, 16'h8000, 16'h0000, 1'b1, 8'h00, 8'h01}, 1'b1, '{8'h00, ST_FULL});

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      phase_mask = (p == 6) ? 8'($urandom) : PHASE_MASKS[p];
      write_valid_mask(phase_mask);
      tx_quiet = (p == 2 || p == 6);
      rx_quiet <= (p == 2 || p == 6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) wait_idle();
        send_request(random_request(), 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
